/* rtl/core/utf8_aware_byte_tokenizer_defines.svh */
// Assertion macros shared by the tokenizer RTL.
`ifndef UTF8_AWARE_BYTE_TOKENIZER_DEFINES_SVH
`define UTF8_AWARE_BYTE_TOKENIZER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define UABT_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define UABT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/uabt_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package uabt_pkg;

    // Most result items a single input item can cause.
    localparam int RES_MAX = 5;

    // Result kinds.
    localparam logic KIND_TOKEN  = 1'b0;
    localparam logic KIND_MARKER = 1'b1;

    // Byte class boundaries and UTF-8 lead patterns.
    localparam logic [7:0] ASCII_LIMIT = 8'h80;
    localparam logic [7:0] LEAD2_MASK  = 8'hE0;
    localparam logic [7:0] LEAD2_CODE  = 8'hC0;
    localparam logic [7:0] LEAD3_MASK  = 8'hF0;
    localparam logic [7:0] LEAD3_CODE  = 8'hE0;
    localparam logic [7:0] LEAD4_MASK  = 8'hF8;
    localparam logic [7:0] LEAD4_CODE  = 8'hF0;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       is_last;
    } in_item_t;

    typedef struct packed {
        logic       kind;
        logic [7:0] out_byte;
        logic       starts_token;
        logic       last_of_run;
    } out_item_t;

    typedef out_item_t [RES_MAX-1:0] res_vec_t;

    typedef logic [2:0][7:0] held_vec_t;

    // Tokenizer state that survives between input items.
    typedef struct packed {
        logic       in_ascii_word;
        logic [1:0] held_count;
        logic [1:0] needed_count;
    } state_t;

    // Write request into the held byte store.
    typedef struct packed {
        logic       en;
        logic [1:0] idx;
        logic [7:0] data;
    } hold_wr_t;

    function automatic logic [7:0] lower_byte(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) ? c + 8'h20 : c;
    endfunction

    // ASCII whitespace and punctuation.
    function automatic logic is_delim(input logic [7:0] c);
        return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D) ||
               (c >= 8'h21 && c <= 8'h2F) || (c >= 8'h3A && c <= 8'h40) ||
               (c >= 8'h5B && c <= 8'h60) || (c >= 8'h7B && c <= 8'h7E);
    endfunction

    // Sequence length a byte at or above 0x80 calls for; 1 when not a lead.
    function automatic logic [2:0] seq_len(input logic [7:0] c);
        if ((c & LEAD2_MASK) == LEAD2_CODE) return 3'd2;
        if ((c & LEAD3_MASK) == LEAD3_CODE) return 3'd3;
        if ((c & LEAD4_MASK) == LEAD4_CODE) return 3'd4;
        return 3'd1;
    endfunction

    function automatic out_item_t make_tok(input logic [7:0] b, input logic start);
        out_item_t r;
        r.kind         = KIND_TOKEN;
        r.out_byte     = b;
        r.starts_token = start;
        r.last_of_run  = 1'b0;
        return r;
    endfunction

    function automatic out_item_t make_marker();
        out_item_t r;
        r.kind         = KIND_MARKER;
        r.out_byte     = 8'h00;
        r.starts_token = 1'b0;
        r.last_of_run  = 1'b0;
        return r;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/uabt_step.sv */
`timescale 1ns / 1ps
`default_nettype none

// Combinational step: from one registered input item and the current state,
// builds the list of result items and the next state.
module uabt_step (
    input  wire uabt_pkg::in_item_t  item,
    input  wire uabt_pkg::state_t    st,
    input  wire uabt_pkg::held_vec_t held,
    output uabt_pkg::res_vec_t       res,
    output logic [2:0]               res_count,
    output uabt_pkg::state_t         st_next,
    output uabt_pkg::hold_wr_t       hold
);

    logic [7:0] c;
    logic       iaw;
    logic       complete;
    logic       pair_done;
    logic [2:0] n;
    logic [2:0] lead_len;

    always_comb
    begin
        c         = uabt_pkg::lower_byte(item.in_byte);
        lead_len  = uabt_pkg::seq_len(c);
        iaw       = st.in_ascii_word;
        n         = 3'd0;
        res       = '0;
        st_next   = st;
        hold      = '0;
        pair_done = 1'b0;
        complete  = (st.held_count != 2'd0) && (st.held_count == st.needed_count);

        if (complete)
        begin
            // The held sequence is finished by this byte: emit it whole.
            res[n] = uabt_pkg::make_tok(held[0], 1'b1);
            n = n + 3'd1;
            if (st.held_count >= 2'd2)
            begin
                res[n] = uabt_pkg::make_tok(held[1], 1'b0);
                n = n + 3'd1;
            end
            if (st.held_count == 2'd3)
            begin
                res[n] = uabt_pkg::make_tok(held[2], 1'b0);
                n = n + 3'd1;
            end
            res[n] = uabt_pkg::make_tok(c, 1'b0);
            n = n + 3'd1;
            st_next.held_count   = 2'd0;
            st_next.needed_count = 2'd0;
            if (item.is_last)
            begin
                res[n] = uabt_pkg::make_marker();
                n = n + 3'd1;
                st_next = '0;
            end
        end
        else if (item.is_last)
        begin
            // Text ends: rescan held bytes plus this byte with nothing after.
            if (st.held_count != 2'd0)
            begin
                // The held lead cannot fit, so it stands alone.
                res[n] = uabt_pkg::make_tok(held[0], 1'b1);
                n = n + 3'd1;
                iaw = 1'b0;
                if (st.held_count == 2'd2)
                begin
                    if (held[1] < uabt_pkg::ASCII_LIMIT)
                    begin
                        if (!uabt_pkg::is_delim(held[1]))
                        begin
                            res[n] = uabt_pkg::make_tok(held[1], 1'b1);
                            n = n + 3'd1;
                            iaw = 1'b1;
                        end
                    end
                    else if (uabt_pkg::seq_len(held[1]) == 3'd2)
                    begin
                        // A two-byte lead that the final byte completes.
                        res[n] = uabt_pkg::make_tok(held[1], 1'b1);
                        n = n + 3'd1;
                        res[n] = uabt_pkg::make_tok(c, 1'b0);
                        n = n + 3'd1;
                        pair_done = 1'b1;
                    end
                    else
                    begin
                        res[n] = uabt_pkg::make_tok(held[1], 1'b1);
                        n = n + 3'd1;
                        iaw = 1'b0;
                    end
                end
            end
            if (!pair_done)
            begin
                if (c < uabt_pkg::ASCII_LIMIT)
                begin
                    if (!uabt_pkg::is_delim(c))
                    begin
                        res[n] = uabt_pkg::make_tok(c, !iaw);
                        n = n + 3'd1;
                    end
                end
                else
                begin
                    res[n] = uabt_pkg::make_tok(c, 1'b1);
                    n = n + 3'd1;
                end
            end
            res[n] = uabt_pkg::make_marker();
            n = n + 3'd1;
            st_next = '0;
        end
        else if (st.held_count != 2'd0)
        begin
            // Another tail byte of the held sequence.
            hold.en            = 1'b1;
            hold.idx           = st.held_count;
            hold.data          = c;
            st_next.held_count = st.held_count + 2'd1;
        end
        else if (c < uabt_pkg::ASCII_LIMIT)
        begin
            // Plain ASCII: a delimiter closes the word, others extend or open it.
            if (uabt_pkg::is_delim(c))
            begin
                st_next.in_ascii_word = 1'b0;
            end
            else
            begin
                res[n] = uabt_pkg::make_tok(c, !st.in_ascii_word);
                n = n + 3'd1;
                st_next.in_ascii_word = 1'b1;
            end
        end
        else
        begin
            // High byte: either a lone token or a lead to hold.
            st_next.in_ascii_word = 1'b0;
            if (lead_len == 3'd1)
            begin
                res[n] = uabt_pkg::make_tok(c, 1'b1);
                n = n + 3'd1;
            end
            else
            begin
                hold.en              = 1'b1;
                hold.idx             = 2'd0;
                hold.data            = c;
                st_next.held_count   = 2'd1;
                st_next.needed_count = 2'(lead_len - 3'd1);
            end
        end

        // Flag the final result of the run.
        for (int i = 0; i < uabt_pkg::RES_MAX; i++)
        begin
            res[i].last_of_run = (n == 3'(i + 1));
        end
        res_count = n;
    end

endmodule

`default_nettype wire

/* rtl/core/utf8_aware_byte_tokenizer.sv */
`timescale 1ns / 1ps
`default_nettype none
`include "utf8_aware_byte_tokenizer_defines.svh"

// UTF-8 aware byte tokenizer. Text bytes enter on the byte channel, one item
// per byte with is_last on the final byte; token bytes and an end-of-text
// marker leave on the tok channel. A byte is accepted every cycle as long as
// each byte causes at most one result and tok_ready stays high; the first
// result of a byte passes the input register and then the result buffer
// before it is offered. A byte that completes a multi-byte sequence or ends
// the text can cause up to five results, which drain from a five-entry result
// buffer at one per cycle while tok_ready is high, so the next byte is not
// processed until the last result of the previous one is taken. Bytes that
// are dropped or held cause no result.
module utf8_aware_byte_tokenizer (
    input  wire                     clk,
    input  wire                     rst_n,
    input  wire                     byte_valid,
    output logic                    byte_ready,
    input  wire uabt_pkg::in_item_t byte_data,
    output logic                    tok_valid,
    input  wire                     tok_ready,
    output uabt_pkg::out_item_t     tok_data
);

    uabt_pkg::in_item_t  item_reg, item_next;
    logic                item_valid_reg, item_valid_next;
    uabt_pkg::state_t    state_reg, state_next;
    uabt_pkg::held_vec_t held_reg, held_next;
    uabt_pkg::res_vec_t  res_buf_reg, res_buf_next;
    logic [2:0]          res_cnt_reg, res_cnt_next;
    logic [2:0]          rd_ptr_reg, rd_ptr_next;

    uabt_pkg::res_vec_t  step_res;
    logic [2:0]          step_count;
    uabt_pkg::state_t    step_state;
    uabt_pkg::hold_wr_t  step_hold;

    logic byte_fire;
    logic tok_fire;
    logic buf_free;
    logic transfer;

    uabt_step u_step (
        .item      (item_reg),
        .st        (state_reg),
        .held      (held_reg),
        .res       (step_res),
        .res_count (step_count),
        .st_next   (step_state),
        .hold      (step_hold)
    );

    // Handshake and transfer from the input register into the result buffer.
    assign tok_valid  = (rd_ptr_reg != res_cnt_reg);
    assign tok_data   = res_buf_reg[rd_ptr_reg];
    assign tok_fire   = tok_valid && tok_ready;
    assign buf_free   = !tok_valid || (tok_fire && (rd_ptr_reg == res_cnt_reg - 3'd1));
    assign transfer   = item_valid_reg && buf_free;
    assign byte_ready = !item_valid_reg || transfer;
    assign byte_fire  = byte_valid && byte_ready;

    // Next-state logic.
    always_comb
    begin
        item_next       = byte_fire ? byte_data : item_reg;
        item_valid_next = byte_fire ? 1'b1 : (transfer ? 1'b0 : item_valid_reg);
        state_next      = transfer ? step_state : state_reg;
        held_next       = held_reg;
        if (transfer && step_hold.en)
        begin
            held_next[step_hold.idx] = step_hold.data;
        end
        res_buf_next = transfer ? step_res : res_buf_reg;
        res_cnt_next = transfer ? step_count : res_cnt_reg;
        if (transfer)
        begin
            rd_ptr_next = 3'd0;
        end
        else if (tok_fire)
        begin
            rd_ptr_next = rd_ptr_reg + 3'd1;
        end
        else
        begin
            rd_ptr_next = rd_ptr_reg;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            state_reg      <= '0;
            res_cnt_reg    <= 3'd0;
            rd_ptr_reg     <= 3'd0;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
            state_reg      <= state_next;
            res_cnt_reg    <= res_cnt_next;
            rd_ptr_reg     <= rd_ptr_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        item_reg    <= item_next;
        held_reg    <= held_next;
        res_buf_reg <= res_buf_next;
    end

    `UABT_ASSERT_IMPL(a_held_le_needed, clk, rst_n, 1'b1, state_reg.held_count <= state_reg.needed_count, "held count exceeds needed count")
    `UABT_ASSERT_IMPL(a_no_word_while_held, clk, rst_n, state_reg.held_count != 2'd0, !state_reg.in_ascii_word, "ASCII word open while a sequence is held")
    `UABT_ASSERT_IMPL(a_rd_ptr_bound, clk, rst_n, 1'b1, rd_ptr_reg <= res_cnt_reg, "read pointer past result count")
    `UABT_ASSERT_NEXT(a_results_shown, clk, rst_n, transfer && step_count != 3'd0, tok_valid, "results loaded but not offered")
    `UABT_ASSERT_IMPL(a_marker_ends_run, clk, rst_n, tok_valid && tok_data.kind == uabt_pkg::KIND_MARKER, tok_data.last_of_run, "end marker not last of its run")

endmodule

`default_nettype wire

/* tb/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;

    localparam int QUIET_LIMIT = 2000;
    localparam int TAIL_CYCLES = 20;
    localparam int RANDOM_ITEMS = 435;

    // One stimulus item, with an optional typed-in expectation.
    typedef struct packed {
        logic [7:0]         b;
        logic               last;
        logic               typed;
        logic [2:0]         n;
        uabt_pkg::res_vec_t res;
    } text_row_t;

    localparam uabt_pkg::out_item_t NONE = '0;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                byte_valid = 1'b0;
    logic                byte_ready;
    uabt_pkg::in_item_t  byte_data = '0;
    logic                tok_valid;
    logic                tok_ready = 1'b0;
    uabt_pkg::out_item_t tok_data;

    // Predictor state.
    logic       word_open;
    logic [7:0] held_buf [3];
    logic [1:0] held_n;
    logic [1:0] need_n;

    uabt_pkg::out_item_t tok_run_q [$];
    uabt_pkg::out_item_t tok_expect_q [$];
    text_row_t           text_rows [$];
    text_row_t           inflight_rows [$];

    int unsigned         errors = 0;
    int unsigned         quiet_cycles = 0;
    int unsigned         rx_calm_left = 0;
    int unsigned         rx_stall_left = 0;
    bit                  rx_calm = 1'b0;
    text_row_t           cur_row;
    uabt_pkg::out_item_t want;

    utf8_aware_byte_tokenizer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .byte_valid(byte_valid),
        .byte_ready(byte_ready),
        .byte_data (byte_data),
        .tok_valid (tok_valid),
        .tok_ready (tok_ready),
        .tok_data  (tok_data)
    );

    always #5 clk = ~clk;

    // Builders for token and marker result items.
    function automatic uabt_pkg::out_item_t tk(input logic [7:0] b, input logic s,
                                               input logic l);
        uabt_pkg::out_item_t r;
        r.kind         = uabt_pkg::KIND_TOKEN;
        r.out_byte     = b;
        r.starts_token = s;
        r.last_of_run  = l;
        return r;
    endfunction

    function automatic uabt_pkg::out_item_t marker_res();
        uabt_pkg::out_item_t r;
        r.kind         = uabt_pkg::KIND_MARKER;
        r.out_byte     = 8'h00;
        r.starts_token = 1'b0;
        r.last_of_run  = 1'b1;
        return r;
    endfunction

    function automatic text_row_t row_of(input logic [7:0] b, input logic last,
                                         input logic typed, input int n,
                                         input uabt_pkg::out_item_t r0,
                                         input uabt_pkg::out_item_t r1);
        text_row_t r;
        r.b      = b;
        r.last   = last;
        r.typed  = typed;
        r.n      = n[2:0];
        r.res    = '0;
        r.res[0] = r0;
        r.res[1] = r1;
        return r;
    endfunction

    function automatic logic [7:0] fold_case(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) ? c + 8'h20 : c;
    endfunction

    // ASCII whitespace and punctuation end a word and are dropped.
    function automatic bit is_sep(input logic [7:0] c);
        return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D) ||
               (c >= 8'h21 && c <= 8'h2F) || (c >= 8'h3A && c <= 8'h40) ||
               (c >= 8'h5B && c <= 8'h60) || (c >= 8'h7B && c <= 8'h7E);
    endfunction

    // Whole sequence length a high byte asks for; 1 when it is no lead.
    function automatic int utf8_len(input logic [7:0] c);
        if ((c & uabt_pkg::LEAD2_MASK) == uabt_pkg::LEAD2_CODE) return 2;
        if ((c & uabt_pkg::LEAD3_MASK) == uabt_pkg::LEAD3_CODE) return 3;
        if ((c & uabt_pkg::LEAD4_MASK) == uabt_pkg::LEAD4_CODE) return 4;
        return 1;
    endfunction

    task automatic take_ascii(input logic [7:0] c);
        if (is_sep(c)) begin
            word_open = 1'b0;
        end
        else begin
            tok_run_q.push_back(tk(c, !word_open, 1'b0));
            word_open = 1'b1;
        end
    endtask

    // Computes the result items caused by one accepted text byte.
    task automatic tokenize_byte(input uabt_pkg::in_item_t it);
        logic [7:0]          c;
        logic [7:0]          seq [4];
        int                  m;
        int                  i;
        int                  len;
        int                  k;
        uabt_pkg::out_item_t r;
        tok_run_q.delete();
        c = fold_case(it.in_byte);
        if (held_n != 0 && held_n == need_n) begin
            // The byte completes the held sequence.
            for (k = 0; k < held_n; k++)
                tok_run_q.push_back(tk(held_buf[k], k == 0, 1'b0));
            tok_run_q.push_back(tk(c, 1'b0, 1'b0));
            held_n = 2'd0;
            need_n = 2'd0;
            if (it.is_last)
                tok_run_q.push_back(marker_res());
        end
        else if (it.is_last) begin
            // The text ends: rescan held bytes plus this one.
            m = 0;
            for (k = 0; k < held_n; k++)
            begin
                seq[m] = held_buf[k];
                m++;
            end
            seq[m] = c;
            m++;
            if (held_n != 0)
                word_open = 1'b0;
            i = 0;
            while (i < m)
            begin
                if (seq[i] < uabt_pkg::ASCII_LIMIT) begin
                    take_ascii(seq[i]);
                    i++;
                end
                else begin
                    len = utf8_len(seq[i]);
                    word_open = 1'b0;
                    if (i + len > m)
                        len = 1;
                    for (k = 0; k < len; k++)
                        tok_run_q.push_back(tk(seq[i + k], k == 0, 1'b0));
                    i += len;
                end
            end
            tok_run_q.push_back(marker_res());
        end
        else if (held_n != 0) begin
            if (held_n < 3)
                held_buf[held_n] = c;
            held_n = held_n + 2'd1;
        end
        else if (c < uabt_pkg::ASCII_LIMIT) begin
            take_ascii(c);
        end
        else begin
            len = utf8_len(c);
            word_open = 1'b0;
            if (len == 1) begin
                tok_run_q.push_back(tk(c, 1'b1, 1'b0));
            end
            else begin
                held_buf[0] = c;
                held_n = 2'd1;
                need_n = 2'(len - 1);
            end
        end
        if (it.is_last) begin
            word_open = 1'b0;
            held_n = 2'd0;
            need_n = 2'd0;
        end
        if (tok_run_q.size() > 0) begin
            r = tok_run_q.pop_back();
            r.last_of_run = 1'b1;
            tok_run_q.push_back(r);
        end
    endtask

    task automatic note_error(input string msg);
        errors++;
        $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    // Mostly short idle stretches, now and then a long one.
    function automatic int unsigned idle_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 75)
            return $urandom_range(1, 3);
        if (r < 95)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    task automatic put_byte(input logic [7:0] b);
        text_rows.push_back(row_of(b, 1'b0, 1'b0, 0, NONE, NONE));
    endtask

    function automatic logic [7:0] rand_lead(input int len);
        if (len == 2)
            return 8'hC0 | 8'($urandom_range(0, 31));
        if (len == 3)
            return 8'hE0 | 8'($urandom_range(0, 15));
        return 8'hF0 | 8'($urandom_range(0, 7));
    endfunction

    function automatic logic [7:0] rand_tail();
        if ($urandom_range(0, 9) == 0)
            return 8'($urandom_range(0, 255));
        return 8'($urandom_range(8'h80, 8'hBF));
    endfunction

    // Appends one random text: words, separators and UTF-8 sequences,
    // sometimes cut short inside a sequence, with is_last on its final byte.
    task automatic add_random_text();
        int         n_seg;
        int         s;
        int         pick;
        int         len;
        int         k;
        int         v;
        logic [7:0] b;
        text_row_t  r;
        if ($urandom_range(0, 9) == 0) begin
            len = $urandom_range(1, 12);
            for (k = 0; k < len; k++)
                put_byte(8'($urandom_range(0, 255)));
        end
        else begin
            n_seg = $urandom_range(1, 8);
            for (s = 0; s < n_seg; s++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 35) begin
                    len = $urandom_range(1, 6);
                    for (k = 0; k < len; k++)
                    begin
                        v = $urandom_range(0, 99);
                        if (v < 40)
                            b = 8'h61 + 8'($urandom_range(0, 25));
                        else if (v < 65)
                            b = 8'h41 + 8'($urandom_range(0, 25));
                        else if (v < 85)
                            b = 8'h30 + 8'($urandom_range(0, 9));
                        else begin
                            // Control bytes that still form words.
                            v = $urandom_range(0, 27);
                            b = (v < 9) ? 8'(v) : (v < 27) ? 8'(v + 5) : 8'h7F;
                        end
                        put_byte(b);
                    end
                end
                else if (pick < 55) begin
                    len = $urandom_range(1, 2);
                    for (k = 0; k < len; k++)
                    begin
                        b = 8'h20;
                        if ($urandom_range(0, 2) != 0) begin
                            do
                                b = 8'($urandom_range(0, 127));
                            while (!is_sep(b));
                        end
                        put_byte(b);
                    end
                end
                else if (pick < 85) begin
                    len = $urandom_range(2, 4);
                    put_byte(rand_lead(len));
                    for (k = 1; k < len; k++)
                        put_byte(rand_tail());
                end
                else if (pick < 92) begin
                    if ($urandom_range(0, 1) == 0)
                        put_byte(8'($urandom_range(8'h80, 8'hBF)));
                    else
                        put_byte(8'($urandom_range(8'hF8, 8'hFF)));
                end
                else begin
                    put_byte(8'($urandom_range(0, 255)));
                end
            end
            // Sometimes the text stops inside a sequence.
            if ($urandom_range(0, 9) < 3) begin
                len = $urandom_range(2, 4);
                put_byte(rand_lead(len));
                k = $urandom_range(0, len - 2);
                for (s = 0; s < k; s++)
                    put_byte(rand_tail());
            end
        end
        r = text_rows.pop_back();
        r.last = 1'b1;
        text_rows.push_back(r);
    endtask

    // Waits at least one edge, then until nothing is left in flight.
    task automatic wait_drained();
        do
            @(posedge clk);
        while (tok_expect_q.size() != 0 || inflight_rows.size() != 0);
    endtask

    // Presents one item and holds it until the block takes it.
    task automatic push_byte(input text_row_t r);
        uabt_pkg::in_item_t it;
        it.in_byte = r.b;
        it.is_last = r.last;
        inflight_rows.push_back(r);
        byte_valid <= 1'b1;
        byte_data  <= it;
        @(posedge clk);
        while (!byte_ready)
            @(posedge clk);
    endtask

    // Receiver: random stalls, with calm stretches of steady ready.
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (rx_calm_left == 0) begin
                rx_calm_left = $urandom_range(50, 300);
                rx_calm = ($urandom_range(0, 3) == 0);
            end
            else begin
                rx_calm_left--;
            end
            if (!rx_calm && rx_stall_left > 0) begin
                rx_stall_left--;
                tok_ready <= 1'b0;
            end
            else if (!rx_calm && $urandom_range(0, 3) == 0) begin
                rx_stall_left = idle_len() - 1;
                tok_ready <= 1'b0;
            end
            else begin
                tok_ready <= 1'b1;
            end
        end
    end

    // Predicts on accepted text bytes, checks accepted token items,
    // and stops the run when nothing moves for too long.
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (byte_valid && byte_ready) begin
                if (inflight_rows.size() == 0) begin
                    note_error("text item accepted while none was offered");
                end
                else begin
                    cur_row = inflight_rows.pop_front();
                    tokenize_byte({cur_row.b, cur_row.last});
                    if (cur_row.typed) begin
                        for (int k = 0; k < cur_row.n; k++)
                            tok_expect_q.push_back(cur_row.res[k]);
                    end
                    else begin
                        while (tok_run_q.size() != 0)
                            tok_expect_q.push_back(tok_run_q.pop_front());
                    end
                end
            end
            if (tok_valid && tok_ready) begin
                if (tok_expect_q.size() == 0) begin
                    note_error($sformatf("unexpected token item %h", tok_data));
                end
                else begin
                    want = tok_expect_q.pop_front();
                    if (tok_data.kind !== want.kind)
                        note_error($sformatf("kind %b, expected %b",
                                             tok_data.kind, want.kind));
                    if (tok_data.out_byte !== want.out_byte)
                        note_error($sformatf("out_byte %h, expected %h",
                                             tok_data.out_byte, want.out_byte));
                    if (tok_data.starts_token !== want.starts_token)
                        note_error($sformatf("starts_token %b, expected %b (byte %h)",
                                             tok_data.starts_token, want.starts_token,
                                             want.out_byte));
                    if (tok_data.last_of_run !== want.last_of_run)
                        note_error($sformatf("last_of_run %b, expected %b (byte %h)",
                                             tok_data.last_of_run, want.last_of_run,
                                             want.out_byte));
                end
            end
            if ((byte_valid && byte_ready) || (tok_valid && tok_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("watchdog: no item moved for %0d cycles", QUIET_LIMIT);
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        int unsigned gap;
        int unsigned tx_calm_left;
        bit          tx_calm;
        bit          hold;
        int          idx;
        text_row_t   r;
        tx_calm_left = 0;
        tx_calm = 1'b0;
        word_open = 1'b0;
        held_n = 2'd0;
        need_n = 2'd0;

        // Directed text: extremes, all byte classes and sequence lengths,
        // sequence completing on the final byte, text ending while holding.
        text_rows.push_back(row_of(8'h41, 1'b0, 1'b1, 1, tk(8'h61, 1'b1, 1'b1), NONE));
        text_rows.push_back(row_of(8'h7A, 1'b0, 1'b1, 1, tk(8'h7A, 1'b0, 1'b1), NONE));
        text_rows.push_back(row_of(8'h20, 1'b0, 1'b1, 0, NONE, NONE));
        text_rows.push_back(row_of(8'h00, 1'b0, 1'b1, 1, tk(8'h00, 1'b1, 1'b1), NONE));
        text_rows.push_back(row_of(8'h7F, 1'b0, 1'b1, 1, tk(8'h7F, 1'b0, 1'b1), NONE));
        text_rows.push_back(row_of(8'hFF, 1'b0, 1'b1, 1, tk(8'hFF, 1'b1, 1'b1), NONE));
        text_rows.push_back(row_of(8'h80, 1'b0, 1'b1, 1, tk(8'h80, 1'b1, 1'b1), NONE));
        text_rows.push_back(row_of(8'hC3, 1'b0, 1'b1, 0, NONE, NONE));
        text_rows.push_back(row_of(8'hA9, 1'b0, 1'b0, 0, NONE, NONE));
        text_rows.push_back(row_of(8'hE2, 1'b0, 1'b1, 0, NONE, NONE));
        text_rows.push_back(row_of(8'h82, 1'b0, 1'b1, 0, NONE, NONE));
        text_rows.push_back(row_of(8'hAC, 1'b0, 1'b0, 0, NONE, NONE));
        text_rows.push_back(row_of(8'hF0, 1'b0, 1'b1, 0, NONE, NONE));
        text_rows.push_back(row_of(8'h9F, 1'b0, 1'b1, 0, NONE, NONE));
        text_rows.push_back(row_of(8'h98, 1'b0, 1'b1, 0, NONE, NONE));
        text_rows.push_back(row_of(8'h80, 1'b1, 1'b0, 0, NONE, NONE));
        text_rows.push_back(row_of(8'h2E, 1'b1, 1'b1, 1, marker_res(), NONE));
        text_rows.push_back(row_of(8'h5A, 1'b1, 1'b1, 2, tk(8'h7A, 1'b1, 1'b0),
                                   marker_res()));
        text_rows.push_back(row_of(8'hF7, 1'b0, 1'b1, 0, NONE, NONE));
        text_rows.push_back(row_of(8'h41, 1'b0, 1'b1, 0, NONE, NONE));
        text_rows.push_back(row_of(8'h42, 1'b1, 1'b0, 0, NONE, NONE));
        text_rows.push_back(row_of(8'hE2, 1'b0, 1'b1, 0, NONE, NONE));
        text_rows.push_back(row_of(8'h41, 1'b1, 1'b0, 0, NONE, NONE));
        text_rows.push_back(row_of(8'hC3, 1'b0, 1'b1, 0, NONE, NONE));
        text_rows.push_back(row_of(8'hC3, 1'b1, 1'b0, 0, NONE, NONE));
        idx = text_rows.size();

        // Random texts follow the directed part.
        while (text_rows.size() < idx + RANDOM_ITEMS)
            add_random_text();

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < text_rows.size(); i++)
        begin
            r = text_rows[i];
            push_byte(r);
            if (tx_calm_left == 0) begin
                tx_calm_left = $urandom_range(20, 80);
                tx_calm = ($urandom_range(0, 3) == 0);
            end
            else begin
                tx_calm_left--;
            end
            // Let everything drain once after the directed part, then at random.
            hold = (i == idx - 1) || ($urandom_range(0, 59) == 0);
            gap = (tx_calm || $urandom_range(0, 99) < 60) ? 0 : idle_len();
            if (gap > 0 || hold) begin
                byte_valid <= 1'b0;
                if (hold)
                    wait_drained();
                repeat (gap) @(posedge clk);
            end
        end
        byte_valid <= 1'b0;

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
